>>> rtl/frpm_pkg.sv
// Package with the shared types and constants of the front/rear plate matcher.
package frpm_pkg;

   localparam logic [7:0] UNKNOWN_MARK = 8'h2A;
   localparam logic [7:0] MAX_AGE_RESET = 8'd15;
   localparam logic [7:0] NO_COLOR_RESET = 8'd11;

   localparam logic [7:0] REG_MAX_AGE = 8'd0;
   localparam logic [7:0] REG_NO_COLOR = 8'd1;

   localparam logic [1:0] STATUS_NONE = 2'd0;
   localparam logic [1:0] STATUS_PLATE = 2'd1;
   localparam logic [1:0] STATUS_ALARM = 2'd2;

   localparam logic CMD_STORE = 1'b0;
   localparam logic CMD_MATCH = 1'b1;

   localparam logic [1:0] LANE_ONE = 2'd1;
   localparam logic [1:0] LANE_TWO = 2'd2;

   typedef struct packed {
      logic        cmd;
      logic [1:0]  lane;
      logic [63:0] plate_text;
      logic [7:0]  vehicle_type;
      logic [7:0]  color_primary;
      logic [7:0]  color_secondary;
      logic [31:0] capture_time;
      logic [31:0] record_tag;
      logic [31:0] now_seconds;
   } req_type;

   typedef struct packed {
      logic [1:0]  match_status;
      logic [1:0]  found_lane;
      logic [31:0] found_tag;
      logic [31:0] found_time;
   } rsp_type;

   typedef struct packed {
      logic [63:0] plate;
      logic [7:0]  vtype;
      logic [7:0]  col1;
      logic [7:0]  col2;
      logic [31:0] ctime;
      logic [31:0] tag;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [1:0] {
      OP_STORE,
      OP_DROP,
      OP_MATCH,
      OP_MISS
   } op_type;

   typedef struct packed {
      op_type  op;
      logic    sel;
      logic    unknown;
      req_type req;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } qhead_type;

   typedef struct packed {
      logic [7:0] max_age;
      logic [7:0] no_color;
   } cfg_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SRCH_RD,
      BK_SRCH_CMP,
      BK_SHIFT_RD,
      BK_SHIFT_WR,
      BK_DONE
   } bk_state_type;

endpackage

>>> rtl/frpm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module frpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/frpm_front.sv
// Front part: accepts requests, classifies them and holds them in a short queue.
module frpm_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  frpm_pkg::req_type req_data,
   output frpm_pkg::qhead_type qhead,
   input  logic              q_pop
);
   import frpm_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push_ok;
   logic       pop_ok;
   item_type   cls;

   always_comb begin
      cls.req = req_data;
      cls.sel = (req_data.lane == LANE_TWO);
      cls.unknown = (req_data.plate_text[7:0] == UNKNOWN_MARK);
      unique case (req_data.lane) inside
         LANE_ONE, LANE_TWO: cls.op = (req_data.cmd == CMD_STORE) ? OP_STORE : OP_MATCH;
         default:            cls.op = (req_data.cmd == CMD_STORE) ? OP_DROP : OP_MISS;
      endcase
   end

   assign req_full = (fill_ff == 2'd2);
   assign push_ok = req_push && !req_full;
   assign pop_ok = q_pop && (fill_ff != 2'd0);
   assign wr_ptr_in = wr_ptr_ff ^ push_ok;
   assign rd_ptr_in = rd_ptr_ff ^ pop_ok;
   assign fill_in = fill_ff + {1'b0, push_ok} - {1'b0, pop_ok};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= cls;
      end
   end

   assign qhead.valid = (fill_ff != 2'd0);
   assign qhead.item = slot_ff[rd_ptr_ff];
endmodule

>>> rtl/frpm_back.sv
// Back part: stores front records, searches and compacts the lane stores, holds the result.
module frpm_back #(
   parameter int LANE_CAPACITY = 128
) (
   input  logic                clock,
   input  logic                reset,
   input  frpm_pkg::qhead_type qhead,
   output logic                q_pop,
   input  frpm_pkg::cfg_type   cfg,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output frpm_pkg::rsp_type   rsp_data
);
   import frpm_pkg::*;

   localparam int IDX_W = (LANE_CAPACITY > 1) ? $clog2(LANE_CAPACITY) : 1;
   localparam int CNT_W = $clog2(LANE_CAPACITY + 1);
   localparam logic [IDX_W:0] CAP_EXT = (IDX_W + 1)'(LANE_CAPACITY);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(LANE_CAPACITY);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] h,
                                             input logic [IDX_W-1:0] o);
      logic [IDX_W:0] s;
      s = {1'b0, h} + {1'b0, o};
      if (s >= CAP_EXT) begin
         s = s - CAP_EXT;
      end
      return s[IDX_W-1:0];
   endfunction

   bk_state_type     state_ff, state_in;
   logic             pass_ff, pass_in;
   logic             cur_ff, cur_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] count_ff [2];
   logic [CNT_W-1:0] count_in [2];
   logic [IDX_W-1:0] head_ff [2];
   logic [IDX_W-1:0] head_in [2];
   rsp_type          res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             wr_en [2];
   logic [IDX_W-1:0] wr_addr;
   logic [IDX_W-1:0] rd_addr;
   entry_type        wr_data;
   logic [ENTRY_W-1:0] rd_raw [2];
   entry_type        ent;

   req_type          rq;
   logic             plate_hit;
   logic             colour_ok;
   logic             stale;
   logic             hit;
   logic signed [32:0] age;
   logic [CNT_W-1:0] pos_next;

   for (genvar g = 0; g < 2; g++) begin : g_lane
      frpm_ram #(.WIDTH(ENTRY_W), .DEPTH(LANE_CAPACITY)) u_ram (
         .clock  (clock),
         .wr_en  (wr_en[g]),
         .wr_addr(wr_addr),
         .wr_data(wr_data),
         .rd_addr(rd_addr),
         .rd_data(rd_raw[g])
      );
   end

   assign rq = qhead.item.req;
   assign ent = entry_type'(rd_raw[cur_ff]);
   assign pos_next = pos_ff + CNT_ONE;

   always_comb begin
      plate_hit = (rq.plate_text == ent.plate) ||
                  (rq.plate_text[39:16] == ent.plate[39:16]) ||
                  (rq.plate_text[47:24] == ent.plate[47:24]) ||
                  (rq.plate_text[55:32] == ent.plate[55:32]) ||
                  (rq.plate_text[63:40] == ent.plate[63:40]);
      age = $signed({1'b0, rq.now_seconds}) - $signed({1'b0, ent.ctime});
      stale = age > $signed({25'd0, cfg.max_age});
      colour_ok = (rq.color_primary == ent.col1) || (rq.color_primary == ent.col2) ||
                  (rq.color_secondary == ent.col1) ||
                  ((ent.col2 != cfg.no_color) && (rq.color_secondary == ent.col2));
      hit = qhead.item.unknown ? (!stale && (rq.vehicle_type == ent.vtype) && colour_ok)
                               : plate_hit;
   end

   always_comb begin
      state_in = state_ff;
      pass_in = pass_ff;
      cur_in = cur_ff;
      pos_in = pos_ff;
      count_in = count_ff;
      head_in = head_ff;
      res_in = res_ff;
      q_pop = 1'b0;
      wr_en[0] = 1'b0;
      wr_en[1] = 1'b0;
      wr_addr = phys(head_ff[cur_ff], pos_ff[IDX_W-1:0]);
      rd_addr = phys(head_ff[cur_ff], pos_ff[IDX_W-1:0]);
      wr_data = ent;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_in = rsp_ff;

      unique case (state_ff)
         BK_IDLE: begin
            if (qhead.valid) begin
               res_in = '0;
               cur_in = qhead.item.sel;
               pass_in = 1'b0;
               pos_in = '0;
               case (qhead.item.op)
                  OP_STORE: begin
                     wr_en[qhead.item.sel] = 1'b1;
                     wr_data.plate = rq.plate_text;
                     wr_data.vtype = rq.vehicle_type;
                     wr_data.col1 = rq.color_primary;
                     wr_data.col2 = rq.color_secondary;
                     wr_data.ctime = rq.capture_time;
                     wr_data.tag = rq.record_tag;
                     if (count_ff[qhead.item.sel] == CAP_CNT) begin
                        // Full store: the new record overwrites the oldest one.
                        wr_addr = head_ff[qhead.item.sel];
                        head_in[qhead.item.sel] =
                           phys(head_ff[qhead.item.sel], IDX_W'(1));
                     end else begin
                        wr_addr = phys(head_ff[qhead.item.sel],
                                       count_ff[qhead.item.sel][IDX_W-1:0]);
                        count_in[qhead.item.sel] = count_ff[qhead.item.sel] + CNT_ONE;
                     end
                     q_pop = 1'b1;
                  end
                  OP_DROP:  q_pop = 1'b1;
                  OP_MISS:  state_in = BK_DONE;
                  default:  state_in = BK_SRCH_RD;
               endcase
            end
         end
         BK_SRCH_RD: begin
            if (pos_ff >= count_ff[cur_ff]) begin
               if (!pass_ff) begin
                  pass_in = 1'b1;
                  cur_in = !cur_ff;
                  pos_in = '0;
               end else begin
                  state_in = BK_DONE;
               end
            end else begin
               state_in = BK_SRCH_CMP;
            end
         end
         BK_SRCH_CMP: begin
            if (hit) begin
               res_in.match_status = qhead.item.unknown ? STATUS_ALARM : STATUS_PLATE;
               res_in.found_lane = cur_ff ? LANE_TWO : LANE_ONE;
               res_in.found_tag = qhead.item.unknown ? ent.tag : 32'd0;
               res_in.found_time = qhead.item.unknown ? ent.ctime : 32'd0;
               state_in = BK_SHIFT_RD;
            end else begin
               pos_in = pos_next;
               state_in = BK_SRCH_RD;
            end
         end
         BK_SHIFT_RD: begin
            rd_addr = phys(head_ff[cur_ff], pos_next[IDX_W-1:0]);
            if (pos_next >= count_ff[cur_ff]) begin
               count_in[cur_ff] = count_ff[cur_ff] - CNT_ONE;
               state_in = BK_DONE;
            end else begin
               state_in = BK_SHIFT_WR;
            end
         end
         BK_SHIFT_WR: begin
            wr_en[cur_ff] = 1'b1;
            pos_in = pos_next;
            state_in = BK_SHIFT_RD;
         end
         BK_DONE: begin
            if (!rsp_valid_ff || rsp_pop) begin
               rsp_valid_in = 1'b1;
               rsp_in = res_ff;
               q_pop = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         count_ff[0] <= '0;
         count_ff[1] <= '0;
         head_ff[0] <= '0;
         head_ff[1] <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         head_ff <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pass_ff <= pass_in;
      cur_ff <= cur_in;
      pos_ff <= pos_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data = rsp_ff;
endmodule

>>> rtl/front_rear_plate_matcher_core.sv
// Top level of the front/rear plate matcher: ports, configuration registers and the two parts.
//
// The block keeps two ordered stores of front-camera records, one per lane, each a
// circular buffer in its own RAM of LANE_CAPACITY entries. The back part writes a store
// request as soon as it takes it; a full store overwrites its oldest record. A match
// request walks its own lane and, without a hit there, then the other, one record at a
// time (RAM read, then compare), and after a hit compacts the store by moving each later
// record down one place, reading and then writing through the single RAM port pair. A
// match also waits at its end until an earlier response has been popped. Every match
// request yields exactly one response; store requests and requests for lanes other than
// 1 and 2 yield none, except a match on such a lane, which answers "not found". A
// two-entry request queue and a response register let requests be pushed while an
// earlier response waits to be popped.
module front_rear_plate_matcher_core #(
   parameter int LANE_CAPACITY = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  frpm_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output frpm_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_index,
   input  logic [7:0]        csr_data
);
   import frpm_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   qhead_type qhead;
   logic      q_pop;

   // Configuration writes are always taken; unknown register indexes are ignored.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_MAX_AGE:  cfg_in.max_age = csr_data;
            REG_NO_COLOR: cfg_in.no_color = csr_data;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_age <= MAX_AGE_RESET;
         cfg_ff.no_color <= NO_COLOR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   frpm_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data(req_data),
      .qhead   (qhead),
      .q_pop   (q_pop)
   );

   frpm_back #(.LANE_CAPACITY(LANE_CAPACITY)) u_back (
      .clock    (clock),
      .reset    (reset),
      .qhead    (qhead),
      .q_pop    (q_pop),
      .cfg      (cfg_ff),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data)
   );
endmodule
